// File: sv/mlfs_pkg.sv
package mlfs_pkg;

   // Process table geometry
   localparam int NPROC  = 8;
   localparam int PROC_W = $clog2(NPROC);
   localparam logic [PROC_W-1:0] TOP_ENTRY = PROC_W'(NPROC - 1);

   localparam int RANK_W  = 2;
   localparam int QUANT_W = 6;
   localparam int TICK_W  = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [RANK_W-1:0]  LOW_RANK    = 2'd2;
   localparam logic [RANK_W-1:0]  NO_RANK     = 2'd3;
   localparam logic [QUANT_W-1:0] QUANT0_RST  = 6'd15;
   localparam logic [QUANT_W-1:0] QUANT1_RST  = 6'd10;
   localparam logic [QUANT_W-1:0] QUANT2_RST  = 6'd5;
   localparam logic [TICK_W-1:0]  PERIOD_RST  = 8'd100;
   localparam logic [TICK_W-1:0]  TICK_MAX    = 8'd255;

   // Operation codes
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_SCHED    = 3'd1;
   localparam logic [2:0] OP_FLUSH    = 3'd2;
   localparam logic [2:0] OP_SET_RANK = 3'd3;
   localparam logic [2:0] OP_REFILL   = 3'd4;

   // Status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_ARG = 2'd1;
   localparam logic [1:0] STAT_NOT_DUE = 2'd2;
   localparam logic [1:0] STAT_NONE    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd3;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] runnable_mask;
      logic [2:0] proc_index;
      logic [1:0] new_rank;
   } req_type;

   typedef struct packed {
      logic [2:0] selected;
      logic       flush_due;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [QUANT_W-1:0] q0;
      logic [QUANT_W-1:0] q1;
      logic [QUANT_W-1:0] q2;
   } quanta_type;

   // Result of evaluating one table entry
   typedef struct packed {
      logic               candidate;
      logic [RANK_W-1:0]  demote_rank;
      logic [QUANT_W-1:0] demote_q;
      logic [QUANT_W-1:0] refill_q;
      logic [QUANT_W-1:0] dec_q;
   } eval_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_TICK   = 8'b0000_0010,
      S_DEMOTE = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_SWEEP  = 8'b0001_0000,
      S_WRITE  = 8'b0010_0000,
      S_RESP   = 8'b0100_0000
   } state_type;

   // Quantum for a rank; a zero register acts as one
   function automatic logic [QUANT_W-1:0] quantum_for(input logic [RANK_W-1:0] rank,
                                                      input quanta_type qt);
      logic [QUANT_W-1:0] q;
      case (rank)
         2'd0:    q = qt.q0;
         2'd1:    q = qt.q1;
         default: q = qt.q2;
      endcase
      return (q == '0) ? QUANT_W'(1) : q;
   endfunction

endpackage

// File: sv/mlfs_eval_unit.sv
module mlfs_eval_unit
   import mlfs_pkg::*;
(
   input  logic [RANK_W-1:0]  rank,
   input  logic [QUANT_W-1:0] quantum,
   input  logic               runnable,
   input  logic [RANK_W-1:0]  best_rank,
   input  quanta_type         quanta,
   output eval_type           eval
);

   always_comb begin
      eval.candidate   = runnable && (rank < best_rank) && (quantum != '0);
      eval.demote_rank = (rank < LOW_RANK) ? rank + RANK_W'(1) : rank;
      eval.demote_q    = quantum_for(eval.demote_rank, quanta);
      eval.refill_q    = quantum_for(rank, quanta);
      eval.dec_q       = (quantum != '0) ? quantum - QUANT_W'(1) : quantum;
   end

endmodule

// File: sv/multilevel_feedback_scheduler.sv
// Three-level feedback scheduler for eight processes. Each request transaction carries an
// op (tick, schedule, flush, set rank, refill quantum) and gets exactly one response
// transaction with the current process, the flush-due flag and a status code. The
// process table (rank and remaining quantum per process) sits in flip-flops and is
// visited one entry per cycle by a single evaluation unit under a small sequencer, so
// the block takes one request at a time and stalls the request side until the response
// has gone. Tick and the table writes make one table write before the response; flush
// sweeps all eight entries; schedule scans the table and, when no process qualifies,
// puts all runnable processes back at rank 0 and scans again; schedule with nothing
// runnable, rejected ops and unused codes go straight to the response. Quantum and
// flush-period registers should only be written while no transaction is in flight.
module multilevel_feedback_scheduler
   import mlfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Configuration
   quanta_type         quanta_ff;
   logic [TICK_W-1:0]  period_ff;

   // Process table
   logic [RANK_W-1:0]  rank_ff  [NPROC];
   logic [QUANT_W-1:0] quant_ff [NPROC];

   // Sequencer state
   state_type          state_ff,  state_in;
   req_type            req_ff,    req_in;
   logic [NPROC-1:0]   mask_ff,   mask_in;
   logic [1:0]         status_ff, status_in;
   logic [PROC_W-1:0]  cur_ff,    cur_in;
   logic [TICK_W-1:0]  tick_ff,   tick_in;
   logic [PROC_W-1:0]  cnt_ff,    cnt_in;
   logic [RANK_W-1:0]  best_ff,   best_in;
   logic [PROC_W-1:0]  pick_ff,   pick_in;
   logic               found_ff,  found_in;
   logic               pass_ff,   pass_in;

   // Table port
   logic [PROC_W-1:0]  addr;
   logic [RANK_W-1:0]  rank_rd;
   logic [QUANT_W-1:0] quant_rd;
   logic               runnable_rd;
   logic               we_rank, we_quant;
   logic [RANK_W-1:0]  wr_rank;
   logic [QUANT_W-1:0] wr_quant;

   eval_type           ev;
   logic [NPROC-1:0]   req_mask;
   logic               idx_bad;
   logic               scan_hit;

   //------------------------------------------------------------------
   // Register writes
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         quanta_ff.q0 <= QUANT0_RST;
         quanta_ff.q1 <= QUANT1_RST;
         quanta_ff.q2 <= QUANT2_RST;
         period_ff    <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUANT0: quanta_ff.q0 <= csr_wdata[QUANT_W-1:0];
            CSR_QUANT1: quanta_ff.q1 <= csr_wdata[QUANT_W-1:0];
            CSR_QUANT2: quanta_ff.q2 <= csr_wdata[QUANT_W-1:0];
            CSR_PERIOD: period_ff    <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // Single table port: one entry read and written per cycle
   //------------------------------------------------------------------
   always_comb begin
      case (state_ff)
         S_SCAN, S_SWEEP: addr = cnt_ff;
         S_WRITE:         addr = PROC_W'(req_ff.proc_index);
         default:         addr = cur_ff;
      endcase
   end

   assign rank_rd     = rank_ff[addr];
   assign quant_rd    = quant_ff[addr];
   assign runnable_rd = mask_ff[addr];

   mlfs_eval_unit u_eval (
      .rank      (rank_rd),
      .quantum   (quant_rd),
      .runnable  (runnable_rd),
      .best_rank (best_ff),
      .quanta    (quanta_ff),
      .eval      (ev)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NPROC; i++) begin
            rank_ff[i]  <= '0;
            quant_ff[i] <= QUANT0_RST;
         end
      end else begin
         if (we_rank)  rank_ff[addr]  <= wr_rank;
         if (we_quant) quant_ff[addr] <= wr_quant;
      end
   end

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   // mask bits beyond the table are dropped
   assign req_mask = NPROC'(req_data.runnable_mask);
   assign idx_bad  = 6'(req_data.proc_index) >= 6'(NPROC);
   assign scan_hit = ev.candidate || found_ff;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      mask_in   = mask_ff;
      status_in = status_ff;
      cur_in    = cur_ff;
      tick_in   = tick_ff;
      cnt_in    = cnt_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      found_in  = found_ff;
      pass_in   = pass_ff;
      we_rank   = 1'b0;
      we_quant  = 1'b0;
      wr_rank   = rank_rd;
      wr_quant  = quant_rd;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               mask_in   = req_mask;
               status_in = STAT_OK;
               cnt_in    = '0;
               best_in   = NO_RANK;
               found_in  = 1'b0;
               pass_in   = 1'b0;
               case (req_data.op)
                  OP_TICK: begin
                     if (tick_ff != TICK_MAX) tick_in = tick_ff + TICK_W'(1);
                     state_in = S_TICK;
                  end
                  OP_SCHED: begin
                     if (req_mask == '0) begin
                        status_in = STAT_NONE;
                        state_in  = S_RESP;
                     end else begin
                        state_in  = S_DEMOTE;
                     end
                  end
                  OP_FLUSH: begin
                     if (tick_ff < period_ff) begin
                        status_in = STAT_NOT_DUE;
                        state_in  = S_RESP;
                     end else begin
                        tick_in   = '0;
                        state_in  = S_SWEEP;
                     end
                  end
                  OP_SET_RANK: begin
                     if (req_data.new_rank > LOW_RANK || idx_bad) begin
                        status_in = STAT_BAD_ARG;
                        state_in  = S_RESP;
                     end else begin
                        state_in  = S_WRITE;
                     end
                  end
                  OP_REFILL: begin
                     if (idx_bad) begin
                        status_in = STAT_BAD_ARG;
                        state_in  = S_RESP;
                     end else begin
                        state_in  = S_WRITE;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end

         // use up one tick of the current process
         S_TICK: begin
            we_quant = 1'b1;
            wr_quant = ev.dec_q;
            state_in = S_RESP;
         end

         // exhausted and runnable: drop a rank (none below the lowest), refill
         S_DEMOTE: begin
            if (quant_rd == '0 && runnable_rd) begin
               we_rank  = 1'b1;
               we_quant = 1'b1;
               wr_rank  = ev.demote_rank;
               wr_quant = ev.demote_q;
            end
            state_in = S_SCAN;
         end

         // first runnable entry of best rank with quantum left
         S_SCAN: begin
            if (ev.candidate) begin
               best_in  = rank_rd;
               pick_in  = cnt_ff;
               found_in = 1'b1;
            end
            if (cnt_ff == TOP_ENTRY) begin
               cnt_in = '0;
               if (scan_hit) begin
                  cur_in   = ev.candidate ? cnt_ff : pick_ff;
                  state_in = S_RESP;
               end else if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               cnt_in = cnt_ff + PROC_W'(1);
            end
         end

         // back to rank 0: all entries on flush, runnable ones on a failed scan
         S_SWEEP: begin
            if (req_ff.op == OP_FLUSH || runnable_rd) begin
               we_rank  = 1'b1;
               we_quant = 1'b1;
               wr_rank  = '0;
               wr_quant = quantum_for('0, quanta_ff);
            end
            if (cnt_ff == TOP_ENTRY) begin
               cnt_in   = '0;
               best_in  = NO_RANK;
               state_in = (req_ff.op == OP_FLUSH) ? S_RESP : S_SCAN;
            end else begin
               cnt_in = cnt_ff + PROC_W'(1);
            end
         end

         S_WRITE: begin
            we_quant = 1'b1;
            if (req_ff.op == OP_SET_RANK) begin
               we_rank  = 1'b1;
               wr_rank  = req_ff.new_rank;
               wr_quant = quantum_for(req_ff.new_rank, quanta_ff);
            end else begin
               wr_quant = ev.refill_q;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= STAT_OK;
         cur_ff    <= '0;
         tick_ff   <= '0;
         cnt_ff    <= '0;
         best_ff   <= NO_RANK;
         pick_ff   <= '0;
         found_ff  <= 1'b0;
         pass_ff   <= 1'b0;
         mask_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         cur_ff    <= cur_in;
         tick_ff   <= tick_in;
         cnt_ff    <= cnt_in;
         best_ff   <= best_in;
         pick_ff   <= pick_in;
         found_ff  <= found_in;
         pass_ff   <= pass_in;
         mask_ff   <= mask_in;
      end
   end

   // request payload, no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   //------------------------------------------------------------------
   // Handshake and response
   //------------------------------------------------------------------
   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_data.selected  = 3'(cur_ff);
   assign rsp_data.flush_due = (tick_ff >= period_ff);
   assign rsp_data.status    = status_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   a_cur_sched_only: assert property (@(posedge clock) disable iff (reset)
      !$stable(cur_ff) |-> ($past(req_ff.op) == OP_SCHED))
      else $error("current process changed outside a schedule");

   // counter clears at the acceptance edge, together with the request capture
   a_tick_drop_flush: assert property (@(posedge clock) disable iff (reset)
      (tick_ff < $past(tick_ff)) |-> (tick_ff == '0 && req_ff.op == OP_FLUSH))
      else $error("tick count fell without a flush");

   a_pick_runnable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && req_ff.op == OP_SCHED && status_ff == STAT_OK) |-> mask_ff[cur_ff])
      else $error("schedule picked a blocked process");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_ff == STAT_NONE) |-> (mask_ff == '0))
      else $error("nothing-runnable status with a runnable process");

endmodule
